@@ sv/motor_command_frame_crc16_assert.svh @@
// Assertion macros used by the frame builder RTL.
// Each macro expands to a labeled concurrent assertion, or to nothing in synthesis.
`ifndef MOTOR_COMMAND_FRAME_CRC16_ASSERT_SVH
`define MOTOR_COMMAND_FRAME_CRC16_ASSERT_SVH

`ifndef SYNTHESIS

`define MCFC_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

`define MCFC_ASSERT_NEVER(name, clk, rst_n, cond) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");

`else

`define MCFC_ASSERT(name, clk, rst_n, prop)

`define MCFC_ASSERT_NEVER(name, clk, rst_n, cond)

`endif

`endif

@@ sv/mcfc_pkg.sv @@
package mcfc_pkg;

  localparam logic [15:0] CrcPoly = 16'h1021;
  localparam logic [15:0] CrcTopBit = 16'h8000;
  localparam logic [7:0] ByteMax = 8'hFF;

  typedef struct packed {
    logic [7:0] left_speed;
    logic [7:0] right_speed;
    logic       left_backward;
    logic       right_backward;
  } cmd_t;

  typedef struct packed {
    logic       port;
    logic [7:0] frame_byte;
    logic       final_byte;
  } frame_beat_t;

  typedef struct packed {
    logic        r_dir;
    logic        l_dir;
    logic [7:0]  r_speed;
    logic [7:0]  l_speed;
    logic [15:0] r_crc;
    logic [15:0] l_crc;
  } work_t;

  typedef enum logic [1:0] {
    REG_ADDRESS    = 2'd0,
    REG_LEFT_GAIN  = 2'd1,
    REG_RIGHT_GAIN = 2'd2,
    REG_NONE       = 2'd3
  } reg_idx_e;

  typedef enum logic [1:0] {
    SEL_ADDR  = 2'd0,
    SEL_DIR   = 2'd1,
    SEL_SPEED = 2'd2
  } crc_sel_e;

  typedef enum logic [2:0] {
    POS_ADDR   = 3'd0,
    POS_DIR    = 3'd1,
    POS_SPEED  = 3'd2,
    POS_CRC_HI = 3'd3,
    POS_CRC_LO = 3'd4
  } pos_e;

  function automatic logic [15:0] crc16_update(logic [15:0] crc_in, logic [7:0] data);
    logic [15:0] crc;
    crc = crc_in ^ {data, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if ((crc & CrcTopBit) != 16'h0000) begin
        crc = {crc[14:0], 1'b0} ^ CrcPoly;
      end else begin
        crc = {crc[14:0], 1'b0};
      end
    end
    return crc;
  endfunction

endpackage

@@ sv/motor_command_frame_crc16.sv @@
// The first byte is offered after the scale, address, direction and speed CRC stages.
// The ten bytes of a command follow one per cycle while the output is ready.
// The serializer accepts a new command as the final byte of the current one is taken.
// Commands queue in the four pipeline stages while the serializer is busy.
// Reset empties the pipeline and sets the address to 0 and both gains to 256.
`include "motor_command_frame_crc16_assert.svh"

module motor_command_frame_crc16 (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [3:0]             paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  mcfc_pkg::cmd_t         in_data_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output mcfc_pkg::frame_beat_t  out_data_o
);

  logic [7:0]         address_q;
  logic [8:0]         left_gain_q;
  logic [8:0]         right_gain_q;
  mcfc_pkg::reg_idx_e reg_idx;
  logic               cfg_write;

  logic            s1_valid;
  logic            s1_ready;
  mcfc_pkg::work_t s1_work;
  logic            s2_valid;
  logic            s2_ready;
  mcfc_pkg::work_t s2_work;
  logic            s3_valid;
  logic            s3_ready;
  mcfc_pkg::work_t s3_work;
  logic            s4_valid;
  logic            s4_ready;
  mcfc_pkg::work_t s4_work;

  logic            out_fire;
  logic            out_final;

  assign reg_idx = mcfc_pkg::reg_idx_e'(paddr[3:2]);
  assign cfg_write = psel && penable && pwrite && pready;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      address_q <= 8'd0;
      left_gain_q <= 9'd256;
      right_gain_q <= 9'd256;
    end else if (cfg_write) begin
      unique case (reg_idx)
        mcfc_pkg::REG_ADDRESS:    address_q <= pwdata[7:0];
        mcfc_pkg::REG_LEFT_GAIN:  left_gain_q <= pwdata[8:0];
        mcfc_pkg::REG_RIGHT_GAIN: right_gain_q <= pwdata[8:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      mcfc_pkg::REG_ADDRESS:    prdata = {24'd0, address_q};
      mcfc_pkg::REG_LEFT_GAIN:  prdata = {23'd0, left_gain_q};
      mcfc_pkg::REG_RIGHT_GAIN: prdata = {23'd0, right_gain_q};
      default:                  prdata = 32'd0;
    endcase
  end

  mcfc_scale u_scale (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .left_gain_i  (left_gain_q),
    .right_gain_i (right_gain_q),
    .valid_i      (in_valid_i),
    .ready_o      (in_ready_o),
    .cmd_i        (in_data_i),
    .valid_o      (s1_valid),
    .ready_i      (s1_ready),
    .work_o       (s1_work)
  );

  mcfc_crc_step u_crc_addr (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .sel_i     (mcfc_pkg::SEL_ADDR),
    .address_i (address_q),
    .valid_i   (s1_valid),
    .ready_o   (s1_ready),
    .work_i    (s1_work),
    .valid_o   (s2_valid),
    .ready_i   (s2_ready),
    .work_o    (s2_work)
  );

  mcfc_crc_step u_crc_dir (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .sel_i     (mcfc_pkg::SEL_DIR),
    .address_i (address_q),
    .valid_i   (s2_valid),
    .ready_o   (s2_ready),
    .work_i    (s2_work),
    .valid_o   (s3_valid),
    .ready_i   (s3_ready),
    .work_o    (s3_work)
  );

  mcfc_crc_step u_crc_speed (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .sel_i     (mcfc_pkg::SEL_SPEED),
    .address_i (address_q),
    .valid_i   (s3_valid),
    .ready_o   (s3_ready),
    .work_i    (s3_work),
    .valid_o   (s4_valid),
    .ready_i   (s4_ready),
    .work_o    (s4_work)
  );

  mcfc_serializer u_serializer (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .address_i   (address_q),
    .valid_i     (s4_valid),
    .ready_o     (s4_ready),
    .work_i      (s4_work),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  assign out_fire = out_valid_o && out_ready_i;
  assign out_final = out_valid_o && out_data_o.final_byte;

  `MCFC_ASSERT(a_frame_unbroken, clk_i, rst_ni, out_fire && !out_data_o.final_byte |=> out_valid_o)
  `MCFC_ASSERT_NEVER(a_final_on_left, clk_i, rst_ni, out_final && !out_data_o.port)
  `MCFC_ASSERT(a_stage_held, clk_i, rst_ni, s4_valid && !s4_ready |=> s4_valid)

endmodule

@@ sv/mcfc_scale.sv @@
module mcfc_scale (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [8:0]          left_gain_i,
  input  logic [8:0]          right_gain_i,
  input  logic                valid_i,
  output logic                ready_o,
  input  mcfc_pkg::cmd_t      cmd_i,
  output logic                valid_o,
  input  logic                ready_i,
  output mcfc_pkg::work_t     work_o
);

  logic            valid_q;
  mcfc_pkg::work_t work_d;
  mcfc_pkg::work_t work_q;
  logic [16:0]     l_prod;
  logic [16:0]     r_prod;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    l_prod = {9'd0, cmd_i.left_speed} * {8'd0, left_gain_i};
    r_prod = {9'd0, cmd_i.right_speed} * {8'd0, right_gain_i};
    work_d.l_dir = cmd_i.left_backward;
    work_d.r_dir = cmd_i.right_backward;
    work_d.l_speed = l_prod[16] ? mcfc_pkg::ByteMax : l_prod[15:8];
    work_d.r_speed = r_prod[16] ? mcfc_pkg::ByteMax : r_prod[15:8];
    work_d.l_crc = 16'h0000;
    work_d.r_crc = 16'h0000;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      work_q <= work_d;
    end
  end

  assign valid_o = valid_q;
  assign work_o = work_q;

endmodule

@@ sv/mcfc_crc_step.sv @@
module mcfc_crc_step (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  mcfc_pkg::crc_sel_e  sel_i,
  input  logic [7:0]          address_i,
  input  logic                valid_i,
  output logic                ready_o,
  input  mcfc_pkg::work_t     work_i,
  output logic                valid_o,
  input  logic                ready_i,
  output mcfc_pkg::work_t     work_o
);

  logic            valid_q;
  mcfc_pkg::work_t work_d;
  mcfc_pkg::work_t work_q;
  logic [7:0]      l_byte;
  logic [7:0]      r_byte;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    unique case (sel_i)
      mcfc_pkg::SEL_ADDR: begin
        l_byte = address_i;
        r_byte = address_i;
      end
      mcfc_pkg::SEL_DIR: begin
        l_byte = {7'd0, work_i.l_dir};
        r_byte = {7'd0, work_i.r_dir};
      end
      mcfc_pkg::SEL_SPEED: begin
        l_byte = work_i.l_speed;
        r_byte = work_i.r_speed;
      end
      default: begin
        l_byte = 8'h00;
        r_byte = 8'h00;
      end
    endcase
    work_d = work_i;
    work_d.l_crc = mcfc_pkg::crc16_update(work_i.l_crc, l_byte);
    work_d.r_crc = mcfc_pkg::crc16_update(work_i.r_crc, r_byte);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      work_q <= work_d;
    end
  end

  assign valid_o = valid_q;
  assign work_o = work_q;

endmodule

@@ sv/mcfc_serializer.sv @@
module mcfc_serializer (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic [7:0]             address_i,
  input  logic                   valid_i,
  output logic                   ready_o,
  input  mcfc_pkg::work_t        work_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output mcfc_pkg::frame_beat_t  out_data_o
);

  logic            busy_d;
  logic            busy_q;
  logic            side_d;
  logic            side_q;
  mcfc_pkg::pos_e  pos_d;
  mcfc_pkg::pos_e  pos_q;
  mcfc_pkg::work_t work_q;
  logic            last;
  logic            dir;
  logic [7:0]      speed;
  logic [15:0]     crc;

  assign last = side_q && (pos_q == mcfc_pkg::POS_CRC_LO);
  assign ready_o = !busy_q || (out_ready_i && last);

  always_comb begin
    busy_d = busy_q;
    side_d = side_q;
    pos_d = pos_q;
    if (busy_q && out_ready_i) begin
      unique case (pos_q)
        mcfc_pkg::POS_ADDR:   pos_d = mcfc_pkg::POS_DIR;
        mcfc_pkg::POS_DIR:    pos_d = mcfc_pkg::POS_SPEED;
        mcfc_pkg::POS_SPEED:  pos_d = mcfc_pkg::POS_CRC_HI;
        mcfc_pkg::POS_CRC_HI: pos_d = mcfc_pkg::POS_CRC_LO;
        mcfc_pkg::POS_CRC_LO: begin
          pos_d = mcfc_pkg::POS_ADDR;
          side_d = !side_q;
        end
        default:              pos_d = mcfc_pkg::POS_ADDR;
      endcase
      if (last) begin
        busy_d = 1'b0;
      end
    end
    if (valid_i && ready_o) begin
      busy_d = 1'b1;
      side_d = 1'b0;
      pos_d = mcfc_pkg::POS_ADDR;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      side_q <= 1'b0;
      pos_q <= mcfc_pkg::POS_ADDR;
    end else begin
      busy_q <= busy_d;
      side_q <= side_d;
      pos_q <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      work_q <= work_i;
    end
  end

  always_comb begin
    dir = side_q ? work_q.l_dir : work_q.r_dir;
    speed = side_q ? work_q.l_speed : work_q.r_speed;
    crc = side_q ? work_q.l_crc : work_q.r_crc;
    out_data_o.port = side_q;
    out_data_o.final_byte = last;
    unique case (pos_q)
      mcfc_pkg::POS_ADDR:   out_data_o.frame_byte = address_i;
      mcfc_pkg::POS_DIR:    out_data_o.frame_byte = {7'd0, dir};
      mcfc_pkg::POS_SPEED:  out_data_o.frame_byte = speed;
      mcfc_pkg::POS_CRC_HI: out_data_o.frame_byte = crc[15:8];
      mcfc_pkg::POS_CRC_LO: out_data_o.frame_byte = crc[7:0];
      default:              out_data_o.frame_byte = 8'h00;
    endcase
  end

  assign out_valid_o = busy_q;

endmodule
